>>> src/was_pkg.sv
// ----------------------------------------------------------------------------
// was_pkg
// Shared types, command codes and time constants of the weekly alarm
// scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package was_pkg;

    // field widths
    localparam int CMD_W    = 2;
    localparam int DAY_W    = 3;
    localparam int HOUR_W   = 5;
    localparam int MIN_W    = 6;
    localparam int SEC_W    = 6;
    localparam int CFG_W    = 19;
    localparam int SLOT_O_W = 3;
    localparam int MASK_W   = 7;

    // week-minute widths: a point in the week, and the shifted difference
    localparam int WMIN_W = 14;
    localparam int DIST_W = 15;

    // time constants
    localparam logic [WMIN_W-1:0] MIN_PER_HOUR  = WMIN_W'(60);
    localparam logic [WMIN_W-1:0] MIN_PER_DAY   = WMIN_W'(1440);
    localparam logic [DIST_W-1:0] MIN_PER_WEEK  = DIST_W'(10080);
    localparam logic [DIST_W-1:0] TWO_WEEKS     = DIST_W'(20160);
    localparam logic [DAY_W-1:0]  LAST_DAY      = DAY_W'(6);

    // command codes
    localparam logic [CMD_W-1:0] CMD_TICK   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RECOMP = 2'd1;
    localparam logic [CMD_W-1:0] CMD_STOP   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NONE   = 2'd3;

    // slot register fields
    localparam int SLOT_HOUR_HI = 18;
    localparam int SLOT_HOUR_LO = 14;
    localparam int SLOT_MIN_HI  = 13;
    localparam int SLOT_MIN_LO  = 8;
    localparam int SLOT_EN_BIT  = 7;

    // input word
    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [DAY_W-1:0]  day_now;
        logic [HOUR_W-1:0] hour_now;
        logic [MIN_W-1:0]  minute_now;
        logic [SEC_W-1:0]  second_now;
    } t_in_word;

    // result word
    typedef struct packed {
        logic                next_valid;
        logic [SLOT_O_W-1:0] next_slot;
        logic [DAY_W-1:0]    next_day;
        logic                ringing;
        logic                ring_started;
    } t_out_word;

    // controller to datapath
    typedef struct packed {
        logic latch_in;
        logic eval;
        logic issue;
        logic commit;
        logic load_out;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic             match;
        logic             ring;
        logic             issue_last;
        logic             pipe_busy;
    } t_dp_status;

    // minutes from the start of the week to the start of a day
    function automatic logic [WMIN_W-1:0] day_minutes(input logic [DAY_W-1:0] d);
        return WMIN_W'(d) * MIN_PER_DAY;
    endfunction

    // weekday mask bit, day seven never set
    function automatic logic day_bit(input logic [MASK_W-1:0] mask,
                                     input logic [DAY_W-1:0] d);
        logic [MASK_W:0] ext;
        ext = {1'b0, mask};
        return ext[d];
    endfunction

endpackage

`default_nettype wire

>>> src/was_chan_if.sv
// ----------------------------------------------------------------------------
// was_chan_if
// Valid/ready channel carrying one word of a given payload type.
// ----------------------------------------------------------------------------
`default_nettype none

interface was_chan_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> src/was_ctrl.sv
// ----------------------------------------------------------------------------
// was_ctrl
// Sequencer of the alarm scheduler: takes a word, evaluates it, runs the
// candidate scan when needed and hands the result word to the output.
// ----------------------------------------------------------------------------
`default_nettype none

module was_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    input  wire was_pkg::t_dp_status i_status,
    output was_pkg::t_dp_cmd         o_cmd
);
    import was_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EVAL  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       need_scan;

    // a scan runs for recompute, stop, and a tick whose ringing minute is over
    always_comb begin
        need_scan = 1'b0;
        if (i_status.command inside {CMD_RECOMP, CMD_STOP}) begin
            need_scan = 1'b1;
        end else if (i_status.command == CMD_TICK) begin
            need_scan = i_status.ring && !i_status.match;
        end
    end

    // next state and commands
    always_comb begin
        n_state     = r_state;
        n_out_valid = (r_out_valid && !i_out_ready);
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch_in = 1'b1;
                    n_state        = S_EVAL;
                end
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = need_scan ? S_SCAN : S_OUT;
            end
            S_SCAN: begin
                o_cmd.issue = 1'b1;
                if (i_status.issue_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!i_status.pipe_busy) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    // a result word is never overwritten before it is taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> (!r_out_valid || i_out_ready))
        else $error("result word overwritten while pending");

    // a commit never happens while candidates are still in flight
    a_commit_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> (r_state == S_DRAIN) && !i_status.pipe_busy)
        else $error("commit without drain");

endmodule

`default_nettype wire

>>> src/was_datapath.sv
// ----------------------------------------------------------------------------
// was_datapath
// Alarm slot registers, ringing state, and the slot-by-day distance pipeline
// with a running minimum for the upcoming alarm search.
// ----------------------------------------------------------------------------
`default_nettype none

module was_datapath #(
    parameter int ALARM_SLOTS = 5
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [$clog2(ALARM_SLOTS > 1 ? ALARM_SLOTS : 2)-1:0] i_cfg_idx,
    input  wire logic [was_pkg::CFG_W-1:0] i_cfg_data,
    input  wire was_pkg::t_in_word         i_in_word,
    output was_pkg::t_out_word             o_out_word,
    input  wire was_pkg::t_dp_cmd          i_cmd,
    output was_pkg::t_dp_status            o_status
);
    import was_pkg::*;

    localparam int SLOT_W = $clog2(ALARM_SLOTS > 1 ? ALARM_SLOTS : 2);

    logic [CFG_W-1:0]    r_slot_cfg [ALARM_SLOTS];
    t_in_word            r_in;
    logic                r_ring;
    logic                r_started;
    logic                r_up_valid;
    logic [SLOT_O_W-1:0] r_up_slot;
    logic [DAY_W-1:0]    r_up_day;
    logic [WMIN_W-1:0]   r_now;
    logic [SLOT_W-1:0]   r_scan_slot;
    logic [DAY_W-1:0]    r_scan_day;
    logic                r_found;
    logic [DIST_W-1:0]   r_best;
    logic [SLOT_W-1:0]   r_best_slot;
    logic [DAY_W-1:0]    r_best_day;
    logic                r_a_valid, r_b_valid, r_c_valid;
    logic [WMIN_W-1:0]   r_a_at;
    logic [DIST_W-1:0]   r_b_raw, r_c_dist;
    logic [SLOT_W-1:0]   r_a_slot, r_b_slot, r_c_slot;
    logic [DAY_W-1:0]    r_a_day, r_b_day, r_c_day;
    t_out_word           r_out;

    logic [CFG_W-1:0]  up_cfg;
    logic              match;
    logic              sec_zero;
    logic [CFG_W-1:0]  scan_cfg;
    logic              cand_ok;
    logic [WMIN_W-1:0] cand_at;
    logic [WMIN_W-1:0] now_min;
    logic [DIST_W-1:0] raw_sum;
    logic [DIST_W-1:0] red1;
    logic [DIST_W-1:0] red2;
    logic              scan_last;

    // slot registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ALARM_SLOTS; i++) begin
                r_slot_cfg[i] <= '0;
            end
        end else if (i_cfg_we && (32'(i_cfg_idx) < 32'(ALARM_SLOTS))) begin
            r_slot_cfg[i_cfg_idx] <= i_cfg_data;
        end
    end

    // match of the upcoming alarm against the current day, hour and minute
    assign up_cfg   = r_slot_cfg[r_up_slot[SLOT_W-1:0]];
    assign sec_zero = (r_in.second_now == '0);
    always_comb begin
        match = 1'b0;
        if (r_up_valid && (32'(r_up_slot) < 32'(ALARM_SLOTS))) begin
            match = day_bit(up_cfg[MASK_W-1:0], r_in.day_now)
                 && (up_cfg[SLOT_HOUR_HI:SLOT_HOUR_LO] == r_in.hour_now)
                 && (up_cfg[SLOT_MIN_HI:SLOT_MIN_LO] == r_in.minute_now);
        end
    end

    // search origin: current minute plus one
    assign now_min = WMIN_W'(r_in.minute_now) + WMIN_W'(1)
                   + WMIN_W'(r_in.hour_now) * MIN_PER_HOUR
                   + day_minutes(r_in.day_now);

    // candidate for the slot and day under the scan counters
    assign scan_cfg  = r_slot_cfg[r_scan_slot];
    assign cand_ok   = scan_cfg[SLOT_EN_BIT] && day_bit(scan_cfg[MASK_W-1:0], r_scan_day);
    assign cand_at   = WMIN_W'(scan_cfg[SLOT_HOUR_HI:SLOT_HOUR_LO]) * MIN_PER_HOUR
                     + WMIN_W'(scan_cfg[SLOT_MIN_HI:SLOT_MIN_LO])
                     + day_minutes(r_scan_day);
    assign scan_last = (r_scan_slot == SLOT_W'(ALARM_SLOTS - 1)) && (r_scan_day == LAST_DAY);

    // distance shifted by two weeks, then folded into one week
    assign raw_sum = DIST_W'(r_a_at) + TWO_WEEKS - DIST_W'(r_now);
    assign red1    = (r_b_raw >= TWO_WEEKS) ? (r_b_raw - TWO_WEEKS) : r_b_raw;
    assign red2    = (red1 >= MIN_PER_WEEK) ? (red1 - MIN_PER_WEEK) : red1;

    // input word capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_in <= i_in_word;
        end
    end

    // search origin and scan counters, set at evaluation
    always_ff @(posedge i_clk) begin
        if (i_cmd.eval) begin
            r_now       <= now_min;
            r_scan_slot <= '0;
            r_scan_day  <= '0;
        end else if (i_cmd.issue) begin
            if (r_scan_day == LAST_DAY) begin
                r_scan_day  <= '0;
                r_scan_slot <= r_scan_slot + SLOT_W'(1);
            end else begin
                r_scan_day <= r_scan_day + DAY_W'(1);
            end
        end
    end

    // distance pipeline valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            r_a_valid <= i_cmd.issue && cand_ok;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
        end
    end

    // distance pipeline payload
    always_ff @(posedge i_clk) begin
        r_a_at   <= cand_at;
        r_a_slot <= r_scan_slot;
        r_a_day  <= r_scan_day;
        r_b_raw  <= raw_sum;
        r_b_slot <= r_a_slot;
        r_b_day  <= r_a_day;
        r_c_dist <= red2;
        r_c_slot <= r_b_slot;
        r_c_day  <= r_b_day;
    end

    // running minimum, earlier candidate kept on a tie
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_cmd.eval) begin
            r_found <= 1'b0;
        end else if (r_c_valid && (!r_found || (r_c_dist < r_best))) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_c_valid && (!r_found || (r_c_dist < r_best))) begin
            r_best      <= r_c_dist;
            r_best_slot <= r_c_slot;
            r_best_day  <= r_c_day;
        end
    end

    // upcoming alarm and ringing state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring     <= 1'b0;
            r_started  <= 1'b0;
            r_up_valid <= 1'b0;
            r_up_slot  <= '0;
            r_up_day   <= '0;
        end else begin
            if (i_cmd.latch_in) begin
                r_started <= 1'b0;
            end
            if (i_cmd.eval && (r_in.command == CMD_TICK)) begin
                r_ring    <= r_ring || (match && sec_zero);
                r_started <= match && sec_zero && !r_ring;
            end
            if (i_cmd.commit) begin
                if (r_found) begin
                    r_up_valid <= 1'b1;
                    r_up_slot  <= SLOT_O_W'(r_best_slot);
                    r_up_day   <= r_best_day;
                end else begin
                    r_up_valid <= 1'b0;
                    r_up_slot  <= '0;
                end
                if (r_in.command != CMD_RECOMP) begin
                    r_ring <= 1'b0;
                end
            end
        end
    end

    // result word register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out.next_valid   <= r_up_valid;
            r_out.next_slot    <= r_up_valid ? r_up_slot : '0;
            r_out.next_day     <= r_up_valid ? r_up_day : '0;
            r_out.ringing      <= r_ring;
            r_out.ring_started <= r_started;
        end
    end

    assign o_out_word          = r_out;
    assign o_status.command    = r_in.command;
    assign o_status.match      = match;
    assign o_status.ring       = r_ring;
    assign o_status.issue_last = scan_last;
    assign o_status.pipe_busy  = r_a_valid || r_b_valid || r_c_valid;

    // upcoming slot always names an existing slot
    a_slot_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_up_valid |-> (32'(r_up_slot) < 32'(ALARM_SLOTS)))
        else $error("upcoming slot out of range");

    // folded distance lies within one week
    a_dist_folded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_c_valid |-> (r_c_dist < MIN_PER_WEEK))
        else $error("distance not reduced below one week");

    // a start pulse only comes with ringing
    a_start_rings: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_started |-> r_ring)
        else $error("ring start without ringing");

endmodule

`default_nettype wire

>>> src/weekly_alarm_scheduler.sv
// ----------------------------------------------------------------------------
// weekly_alarm_scheduler
// A tick that needs no search, or an unknown command, gives its word once
// it has been evaluated; recompute, stop, and a tick that ends ringing
// scan every slot and day, one candidate a cycle through the distance
// pipeline, and give their word once the pipeline has drained.
// Throughput: one word at a time; the next word is taken the cycle after the
// result is loaded into the output register. Reset clears slots, alarm, ringing.
// ----------------------------------------------------------------------------
`default_nettype none

module weekly_alarm_scheduler #(
    parameter int ALARM_SLOTS = 5
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    was_chan_if.sink                       i_cmd_ch,
    was_chan_if.source                     o_res_ch,
    input  wire logic                      i_cfg_we,
    input  wire logic [$clog2(ALARM_SLOTS > 1 ? ALARM_SLOTS : 2)-1:0] i_cfg_idx,
    input  wire logic [was_pkg::CFG_W-1:0] i_cfg_data
);
    import was_pkg::*;

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;
    t_in_word   in_word;
    t_out_word  out_word;
    logic       in_ready;
    logic       out_valid;

    assign in_word = i_cmd_ch.data;

    // sequencer
    was_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_cmd_ch.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_res_ch.ready),
        .i_status    (dp_status),
        .o_cmd       (dp_cmd)
    );

    // slot registers and search datapath
    was_datapath #(
        .ALARM_SLOTS (ALARM_SLOTS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_word  (in_word),
        .o_out_word (out_word),
        .i_cmd      (dp_cmd),
        .o_status   (dp_status)
    );

    // channel handshakes
    assign i_cmd_ch.ready = in_ready;
    assign o_res_ch.valid = out_valid;
    assign o_res_ch.data  = out_word;

endmodule

`default_nettype wire

>>> tb/alarm_checker.sv
// ----------------------------------------------------------------------------
// alarm_checker
// Watches the command, result and slot write ports of the weekly alarm
// scheduler, keeps its own copy of the alarm slots and the upcoming alarm,
// predicts the result word of every accepted command word and compares each
// accepted result word, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module alarm_checker #(
    parameter int ALARM_SLOTS = 5,
    parameter int CFG_IDX_W   = 3
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cmd_valid,
    input  logic                      i_cmd_ready,
    input  was_pkg::t_in_word         i_cmd_word,
    input  logic                      i_res_valid,
    input  logic                      i_res_ready,
    input  was_pkg::t_out_word        i_res_word,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [was_pkg::CFG_W-1:0] i_cfg_data,
    output int                        o_fail_count,
    output int                        o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import was_pkg::*;

    localparam int unsigned HOUR_MINUTES = 60;
    localparam int unsigned DAY_MINUTES  = 1440;
    localparam int unsigned WEEK_MINUTES = 10080;
    localparam int unsigned WEEK_DAYS    = 7;

    // shadow of the slot registers and of the upcoming alarm
    logic [CFG_W-1:0]    slot_regs [ALARM_SLOTS];
    logic                upcoming_valid;
    logic [SLOT_O_W-1:0] upcoming_slot;
    logic [DAY_W-1:0]    upcoming_day;
    logic                ringing;

    t_out_word expected_words [$];
    t_out_word oldest;

    // pick the enabled slot and day that comes first after the current minute
    function automatic void find_upcoming(input int unsigned day, input int unsigned hour,
                                          input int unsigned minute);
        int unsigned      now_min;
        int unsigned      alarm_min;
        int unsigned      wait_min;
        int unsigned      best;
        bit               found;
        logic [CFG_W-1:0] r;
        now_min = (minute + 1) + hour * HOUR_MINUTES + day * DAY_MINUTES;
        found   = 1'b0;
        best    = 0;
        for (int s = 0; s < ALARM_SLOTS; s++) begin
            r = slot_regs[s];
            if (r[SLOT_EN_BIT]) begin
                for (int d = 0; d < WEEK_DAYS; d++) begin
                    if (r[d]) begin
                        alarm_min = r[SLOT_MIN_HI:SLOT_MIN_LO]
                                  + r[SLOT_HOUR_HI:SLOT_HOUR_LO] * HOUR_MINUTES
                                  + d * DAY_MINUTES;
                        wait_min  = (alarm_min + 2 * WEEK_MINUTES - now_min) % WEEK_MINUTES;
                        if (!found || wait_min < best) begin
                            found         = 1'b1;
                            best          = wait_min;
                            upcoming_slot = SLOT_O_W'(s);
                            upcoming_day  = DAY_W'(d);
                        end
                    end
                end
            end
        end
        upcoming_valid = found;
        if (!found) begin
            upcoming_slot = '0;
        end
    endfunction

    // next state and result word for one command word
    function automatic t_out_word alarm_result(input t_in_word w);
        t_out_word        res;
        logic [CFG_W-1:0] r;
        bit               was_ringing;
        bit               time_match;
        bit               started;
        started    = 1'b0;
        time_match = 1'b0;
        case (w.command)
            CMD_TICK: begin
                was_ringing = ringing;
                if (upcoming_valid && upcoming_slot < ALARM_SLOTS) begin
                    r = slot_regs[upcoming_slot];
                    // day seven matches no weekday
                    if (w.day_now < WEEK_DAYS && r[w.day_now]
                            && r[SLOT_HOUR_HI:SLOT_HOUR_LO] == w.hour_now
                            && r[SLOT_MIN_HI:SLOT_MIN_LO] == w.minute_now) begin
                        time_match = 1'b1;
                        if (w.second_now == '0) begin
                            ringing = 1'b1;
                        end
                    end
                end
                if (ringing) begin
                    if (time_match) begin
                        started = !was_ringing;
                    end else begin
                        // the alarm minute is over
                        find_upcoming(w.day_now, w.hour_now, w.minute_now);
                        ringing = 1'b0;
                    end
                end
            end
            CMD_RECOMP: begin
                find_upcoming(w.day_now, w.hour_now, w.minute_now);
            end
            CMD_STOP: begin
                find_upcoming(w.day_now, w.hour_now, w.minute_now);
                ringing = 1'b0;
            end
            default: begin
            end
        endcase
        res.next_valid   = upcoming_valid;
        res.next_slot    = upcoming_valid ? upcoming_slot : '0;
        res.next_day     = upcoming_valid ? upcoming_day : '0;
        res.ringing      = ringing;
        res.ring_started = started;
        return res;
    endfunction

    task automatic check_field(input string field, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
            o_fail_count++;
        end
    endtask

    // monitor: results first, then new command words, then slot writes
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ALARM_SLOTS; i++) begin
                slot_regs[i] = '0;
            end
            upcoming_valid = 1'b0;
            upcoming_slot  = '0;
            upcoming_day   = '0;
            ringing        = 1'b0;
            o_fail_count   = 0;
            expected_words.delete();
        end else begin
            if (i_res_valid && i_res_ready) begin
                if (expected_words.size() == 0) begin
                    $display("%0t: result word %h with no command word pending",
                             $time, i_res_word);
                    o_fail_count++;
                end else begin
                    oldest = expected_words.pop_front();
                    check_field("next_valid", oldest.next_valid, i_res_word.next_valid);
                    check_field("next_slot", oldest.next_slot, i_res_word.next_slot);
                    check_field("next_day", oldest.next_day, i_res_word.next_day);
                    check_field("ringing", oldest.ringing, i_res_word.ringing);
                    check_field("ring_started", oldest.ring_started,
                                i_res_word.ring_started);
                end
            end
            if (i_cmd_valid && i_cmd_ready) begin
                expected_words.push_back(alarm_result(i_cmd_word));
            end
            // writes beyond the last slot are dropped
            if (i_cfg_we && i_cfg_idx < ALARM_SLOTS) begin
                slot_regs[i_cfg_idx] = i_cfg_data;
            end
        end
        o_pending = expected_words.size();
    end

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Regression of the weekly alarm scheduler: programs several sets of alarm
// slots, sends a directed run through wrap, ringing and stop cases and then
// random alarm sequences and noise, with random gaps on the command side and
// random stalls on the result side. The checker beside the block predicts
// and compares every result word.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import was_pkg::*;

    localparam int ALARM_SLOTS    = 5;
    localparam int CFG_IDX_W      = $clog2(ALARM_SLOTS > 1 ? ALARM_SLOTS : 2);
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_AFTER     = 300;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 50;
    localparam int IDLE_CYCLES    = 4;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_data;
    int                   fail_count;
    int                   pending;

    // stimulus side copy of the slots, used to aim alarm sequences
    logic [CFG_W-1:0] slot_cfg [ALARM_SLOTS];
    int               items_sent;
    int               burst_left;
    int               gap_max;
    int               results_seen;
    int               idle_cycles;

    was_chan_if #(.t_payload(t_in_word))  cmd_ch ();
    was_chan_if #(.t_payload(t_out_word)) res_ch ();

    weekly_alarm_scheduler #(
        .ALARM_SLOTS(ALARM_SLOTS)
    ) dut (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_cmd_ch  (cmd_ch),
        .o_res_ch  (res_ch),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data)
    );

    alarm_checker #(
        .ALARM_SLOTS(ALARM_SLOTS),
        .CFG_IDX_W  (CFG_IDX_W)
    ) u_alarm_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cmd_valid (cmd_ch.valid),
        .i_cmd_ready (cmd_ch.ready),
        .i_cmd_word  (cmd_ch.data),
        .i_res_valid (res_ch.valid),
        .i_res_ready (res_ch.ready),
        .i_res_word  (res_ch.data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // clock
    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic [CFG_W-1:0] pack_slot(input int hour, input int minute,
                                                   input bit en, input int mask);
        return {HOUR_W'(hour), MIN_W'(minute), en, MASK_W'(mask)};
    endfunction

    function automatic t_in_word mk_word(input logic [CMD_W-1:0] command, input int day,
                                         input int hour, input int minute, input int second);
        return t_in_word'({command, DAY_W'(day), HOUR_W'(hour), MIN_W'(minute),
                           SEC_W'(second)});
    endfunction

    // offer one word in bursts with random gaps, return at the next falling edge
    task automatic send_word(input t_in_word w);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap        = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
            if (gap > 0) begin
                cmd_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        cmd_ch.valid <= 1'b1;
        cmd_ch.data  <= w;
        do @(posedge clk); while (!cmd_ch.ready);
        @(negedge clk);
        items_sent++;
    endtask

    // drain the block, then load every slot from slot_cfg
    task automatic apply_slots();
        cmd_ch.valid <= 1'b0;
        wait (pending == 0);
        repeat (IDLE_CYCLES) @(negedge clk);
        // a write past the last slot must be dropped
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_IDX_W'($urandom_range(ALARM_SLOTS, (1 << CFG_IDX_W) - 1));
        cfg_data <= CFG_W'($urandom);
        @(negedge clk);
        for (int i = 0; i < ALARM_SLOTS; i++) begin
            cfg_idx  <= CFG_IDX_W'(i);
            cfg_data <= slot_cfg[i];
            @(negedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    // walk one programmed alarm: recompute just ahead, ring, maybe stop, let it pass
    task automatic alarm_sequence();
        logic [CFG_W-1:0]  r;
        logic [MASK_W-1:0] mask;
        int s, d, h, m, pd, ph, pm, nd, nh, nm, k;
        s    = $urandom_range(0, ALARM_SLOTS - 1);
        r    = slot_cfg[s];
        h    = r[SLOT_HOUR_HI:SLOT_HOUR_LO];
        m    = r[SLOT_MIN_HI:SLOT_MIN_LO];
        mask = r[MASK_W-1:0];
        d    = $urandom_range(0, 6);
        if (mask != '0) begin
            while (!mask[d]) d = $urandom_range(0, 6);
        end
        // minute before the alarm
        pd = d;
        ph = h;
        pm = m - 1;
        if (m == 0) begin
            pm = 59;
            ph = h - 1;
            if (h == 0) begin
                ph = 23;
                pd = (d + 6) % 7;
            end
        end
        // minute after the alarm
        nd = d;
        nh = h;
        nm = m + 1;
        if (m >= 59) begin
            nm = 0;
            nh = h + 1;
            if (h >= 23) begin
                nh = 0;
                nd = (d + 1) % 7;
            end
        end
        send_word(mk_word($urandom_range(0, 3) == 0 ? CMD_STOP : CMD_RECOMP,
                          pd, ph, pm, $urandom_range(0, 59)));
        if ($urandom_range(0, 1) == 1) begin
            send_word(mk_word(CMD_TICK, pd, ph, pm, 59));
        end
        send_word(mk_word(CMD_TICK, d, h, m,
                          $urandom_range(0, 4) == 0 ? $urandom_range(0, 63) : 0));
        k = $urandom_range(0, 4);
        for (int i = 1; i <= k; i++) begin
            send_word(mk_word(CMD_TICK, d, h, m, i * $urandom_range(1, 11)));
        end
        if ($urandom_range(0, 1) == 1) begin
            send_word(mk_word(CMD_STOP, d, h, m, $urandom_range(1, 59)));
            if ($urandom_range(0, 1) == 1) begin
                send_word(mk_word(CMD_TICK, d, h, m, 0));
            end
        end
        if ($urandom_range(0, 3) != 0) begin
            send_word(mk_word(CMD_TICK, nd, nh, nm, $urandom_range(0, 2) == 0 ? 0 : 30));
        end
    endtask

    // mostly alarm sequences, the rest raw words over the full field ranges
    task automatic random_items(input int n);
        int target;
        target = items_sent + n;
        while (items_sent < target) begin
            if ($urandom_range(0, 49) == 0) begin
                // hold back until every result is in
                cmd_ch.valid <= 1'b0;
                wait (pending == 0);
                @(negedge clk);
            end
            if ($urandom_range(0, 99) < 70) begin
                alarm_sequence();
            end else begin
                send_word(mk_word(CMD_W'($urandom_range(CMD_TICK, CMD_NONE)),
                                  $urandom_range(0, 7), $urandom_range(0, 31),
                                  $urandom_range(0, 63),
                                  $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 63)));
            end
        end
    endtask

    // result side stalls, with one long hold-off
    initial begin : res_pacer
        int mode;
        int seg_left;
        int stall_left;
        int hold_left;
        bit held;
        mode         = 0;
        seg_left     = 0;
        stall_left   = 0;
        hold_left    = 0;
        held         = 1'b0;
        res_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (!held && results_seen >= HOLD_AFTER) begin
                held         = 1'b1;
                hold_left    = HOLD_CYCLES;
                res_ch.ready <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end else begin
                if (seg_left == 0) begin
                    seg_left = $urandom_range(50, 300);
                    mode     = $urandom_range(0, 2);
                end
                seg_left--;
                case (mode)
                    0: res_ch.ready <= 1'b1;
                    1: res_ch.ready <= 1'($urandom_range(0, 1));
                    default: begin
                        if (stall_left != 0) begin
                            stall_left--;
                            res_ch.ready <= 1'b0;
                        end else begin
                            stall_left   = $urandom_range(0, 60);
                            res_ch.ready <= 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    // watchdog on cycles with no word moving
    always @(posedge clk) begin
        if (!rst_n) begin
            idle_cycles  <= 0;
            results_seen <= 0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                results_seen <= results_seen + 1;
            end
            if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
                if (idle_cycles >= WATCHDOG_LIMIT) begin
                    $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
                    $display("weekly_alarm_scheduler regression: fail");
                    $finish;
                end
            end
        end
    end

    // main sequence
    initial begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_idx      = '0;
        cfg_data     = '0;
        cmd_ch.valid = 1'b0;
        cmd_ch.data  = '0;
        items_sent   = 0;
        burst_left   = 0;
        gap_max      = 40;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // weekday alarm, weekend alarm, last minute of the week, a disabled
        // slot and an enabled slot with no days
        slot_cfg[0] = pack_slot(7, 30, 1'b1, 'h1F);
        slot_cfg[1] = pack_slot(7, 30, 1'b1, 'h60);
        slot_cfg[2] = pack_slot(23, 59, 1'b1, 'h40);
        slot_cfg[3] = pack_slot(6, 0, 1'b0, 'h7F);
        slot_cfg[4] = pack_slot(12, 0, 1'b1, 'h00);
        apply_slots();
        send_word(mk_word(CMD_TICK, 0, 0, 0, 0));       // no alarm known yet
        send_word(mk_word(CMD_NONE, 6, 23, 59, 59));
        send_word(mk_word(CMD_RECOMP, 6, 23, 59, 30));  // wraps into the next week
        send_word(mk_word(CMD_RECOMP, 6, 23, 58, 0));   // due in the very next minute
        send_word(mk_word(CMD_TICK, 6, 23, 59, 0));     // ringing starts
        send_word(mk_word(CMD_TICK, 6, 23, 59, 1));
        send_word(mk_word(CMD_RECOMP, 6, 23, 59, 2));   // keeps ringing, moves on
        send_word(mk_word(CMD_TICK, 6, 23, 59, 3));     // no longer matches, ends
        send_word(mk_word(CMD_RECOMP, 0, 7, 29, 0));
        send_word(mk_word(CMD_TICK, 0, 7, 30, 5));      // right minute, not second zero
        send_word(mk_word(CMD_TICK, 0, 7, 30, 0));
        send_word(mk_word(CMD_STOP, 0, 7, 30, 10));     // stop while ringing
        send_word(mk_word(CMD_STOP, 0, 7, 30, 11));     // stop with nothing ringing
        send_word(mk_word(CMD_TICK, 0, 7, 30, 0));
        send_word(mk_word(CMD_RECOMP, 0, 7, 29, 0));
        send_word(mk_word(CMD_TICK, 0, 7, 30, 0));
        send_word(mk_word(CMD_TICK, 0, 7, 31, 0));      // minute over
        send_word(mk_word(CMD_RECOMP, 7, 31, 63, 63));  // every time field past range
        send_word(mk_word(CMD_TICK, 7, 7, 30, 0));      // day seven never matches
        send_word(mk_word(CMD_NONE, 7, 31, 63, 63));
        send_word(mk_word(CMD_STOP, 0, 0, 0, 0));
        random_items(220);

        // every slot bit set, sender without gaps
        for (int i = 0; i < ALARM_SLOTS; i++) begin
            slot_cfg[i] = '1;
        end
        gap_max = 0;
        apply_slots();
        random_items(200);

        // same time on all slots, overlapping days
        slot_cfg[0] = pack_slot(6, 15, 1'b1, 'h0C);
        slot_cfg[1] = pack_slot(6, 15, 1'b1, 'h7F);
        slot_cfg[2] = pack_slot(6, 15, 1'b1, 'h0C);
        slot_cfg[3] = pack_slot(6, 15, 1'b1, 'h01);
        slot_cfg[4] = pack_slot(6, 15, 1'b1, 'h7F);
        gap_max = 20;
        apply_slots();
        random_items(220);

        // random slot sets
        repeat (3) begin
            for (int i = 0; i < ALARM_SLOTS; i++) begin
                slot_cfg[i] = pack_slot(
                    $urandom_range(0, 9) == 0 ? $urandom_range(24, 31) : $urandom_range(0, 23),
                    $urandom_range(0, 9) == 0 ? $urandom_range(60, 63) : $urandom_range(0, 59),
                    $urandom_range(0, 4) != 0, $urandom_range(0, 127));
            end
            gap_max = $urandom_range(0, 1) ? 60 : 5;
            apply_slots();
            random_items(280);
        end

        // no alarm at all
        for (int i = 0; i < ALARM_SLOTS; i++) begin
            slot_cfg[i] = '0;
        end
        gap_max = 30;
        apply_slots();
        random_items(100);

        // drain and give the verdict
        cmd_ch.valid <= 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (pending != 0) begin
            $display("%0t: %0d result words never arrived", $time, pending);
        end
        if (fail_count == 0 && pending == 0) begin
            $display("weekly_alarm_scheduler regression: pass");
        end else begin
            $display("weekly_alarm_scheduler regression: fail");
        end
        $finish;
    end

endmodule

>>> files.f
src/was_pkg.sv
src/was_chan_if.sv
src/was_ctrl.sv
src/was_datapath.sv
src/weekly_alarm_scheduler.sv
tb/alarm_checker.sv
tb/testbench.sv
